### hw/rtl/nfpe_pkg.sv
// Shared types and constants for the NOR flash program/erase controller.
// Holds command and error codes, stream widths and controller/datapath structs.
// No dependencies.
package nfpe_pkg;

  localparam int unsigned FlashBytesDef = 65536;

  localparam int unsigned SDataW = 88;
  localparam int unsigned SUserW = 3;
  localparam int unsigned MDataW = 8;

  localparam logic [2:0] KindUnlock = 3'd0;
  localparam logic [2:0] KindLock   = 3'd1;
  localparam logic [2:0] KindProg   = 3'd2;
  localparam logic [2:0] KindErase  = 3'd3;
  localparam logic [2:0] KindQuery  = 3'd4;

  localparam logic [1:0] ErrNone = 2'd0;
  localparam logic [1:0] ErrWrp  = 2'd1;
  localparam logic [1:0] ErrProg = 2'd2;
  localparam logic [1:0] ErrPga  = 2'd3;

  localparam logic [63:0] EraseWord = {8{8'hFF}};

  typedef struct packed {
    logic load;
    logic exec;
    logic sweep_en;
    logic sweep_ones;
  } dp_cmd_t;

  typedef struct packed {
    logic erase_go;
    logic sweep_last;
  } dp_stat_t;

endpackage

### hw/rtl/nor_flash_program_erase_controller_unit.sv
// Top level of the NOR flash program/erase controller.
// Joins nfpe_ctrl and nfpe_dp to the stream ports; uses nfpe_pkg.
//
// Commands (unlock, lock, program, mass erase, error query) arrive one per
// transaction and each returns one result. On acceptance the addressed
// word is registered; StExec checks it once the output register is free,
// and a successful program writes it back through the single store write
// port. A successful mass erase sweeps FLASH_BYTES/8 words (8192 by
// default), one word per cycle, with the input held off; its result is
// delivered as the sweep starts. After reset a clearing pass zeroes every
// store word before the first command is accepted. A result waits in an
// output register, so the next command may be taken while it is pending.
module nor_flash_program_erase_controller_unit import nfpe_pkg::*; #(
  parameter int unsigned FLASH_BYTES = FlashBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // [2:0] size_code, [18:3] byte_address, [82:19] write_data, [87:83] zero
  input  logic [SDataW-1:0] s_axis_tdata_i,
  // [2:0] kind
  input  logic [SUserW-1:0] s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // [0] ok, [2:1] error_code, [3] is_locked, [7:4] zero
  output logic [MDataW-1:0] m_axis_tdata_o
);

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic       ok;
  logic [1:0] error_code;
  logic       is_locked;

  nfpe_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  nfpe_dp #(
    .FlashBytes (FLASH_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .kind_i         (s_axis_tuser_i[2:0]),
    .size_code_i    (s_axis_tdata_i[2:0]),
    .byte_address_i (s_axis_tdata_i[18:3]),
    .write_data_i   (s_axis_tdata_i[82:19]),
    .ok_o           (ok),
    .error_code_o   (error_code),
    .is_locked_o    (is_locked)
  );

  assign m_axis_tdata_o = {4'b0000, is_locked, error_code, ok};

endmodule

### hw/rtl/nfpe_ctrl.sv
// Controller state machine of the NOR flash program/erase controller.
// Drives the stream handshakes and issues dp_cmd_t to nfpe_dp; uses nfpe_pkg.
module nfpe_ctrl import nfpe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  output logic     s_ready_o,
  output logic     m_valid_o,
  input  logic     m_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StExec,
    StErase
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   exec_ok;

  assign exec_ok = (state_q == StExec) && (!out_valid_q || m_ready_i);

  assign s_ready_o        = (state_q == StIdle);
  assign m_valid_o        = out_valid_q;
  assign cmd_o.load       = (state_q == StIdle) && s_valid_i;
  assign cmd_o.exec       = exec_ok;
  assign cmd_o.sweep_en   = (state_q == StClear) || (state_q == StErase);
  assign cmd_o.sweep_ones = (state_q == StErase);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      out_valid_q <= 1'b0;
    end else begin
      if (exec_ok) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StClear: begin
          if (stat_i.sweep_last) state_q <= StIdle;
        end
        StIdle: begin
          if (s_valid_i) state_q <= StExec;
        end
        StExec: begin
          if (exec_ok) state_q <= stat_i.erase_go ? StErase : StIdle;
        end
        StErase: begin
          if (stat_i.sweep_last) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

### hw/rtl/nfpe_dp.sv
// Datapath of the NOR flash program/erase controller: flash store memory,
// command registers, lock and error registers, sweep counter; uses nfpe_pkg.
module nfpe_dp import nfpe_pkg::*; #(
  parameter int unsigned FlashBytes = FlashBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_stat_t    stat_o,
  input  logic [2:0]  kind_i,
  input  logic [2:0]  size_code_i,
  input  logic [15:0] byte_address_i,
  input  logic [63:0] write_data_i,
  output logic        ok_o,
  output logic [1:0]  error_code_o,
  output logic        is_locked_o
);

  localparam int unsigned StoreWords = FlashBytes / 8;
  localparam int unsigned AW = $clog2(StoreWords);
  localparam logic [AW-1:0] LastWord = AW'(StoreWords - 1);

  logic [63:0]   mem [StoreWords];
  logic [63:0]   rd_q;
  logic [2:0]    kind_q;
  logic [2:0]    size_q;
  logic [15:0]   addr_q;
  logic [63:0]   data_q;
  logic          lock_q;
  logic [1:0]    err_q;
  logic          out_ok_q;
  logic [1:0]    out_err_q;
  logic          out_lock_q;
  logic [AW-1:0] cnt_q;

  logic [AW-1:0] raddr;
  logic [AW-1:0] widx;
  logic [63:0]   lane_mask;
  logic [63:0]   lane_sh;
  logic [63:0]   want;
  logic [63:0]   new_word;
  logic          align_bad;
  logic          in_range;
  logic          ok_d;
  logic [1:0]    err_d;
  logic          lock_d;
  logic          we;
  logic          erase_go;

  assign raddr    = AW'(byte_address_i[15:3]);
  assign widx     = AW'(addr_q[15:3]);
  assign in_range = 32'(addr_q[15:3]) < 32'(StoreWords);
  assign lane_sh  = lane_mask << {addr_q[2:0], 3'b000};
  assign want     = (data_q & lane_mask) << {addr_q[2:0], 3'b000};
  assign new_word = rd_q & (want | ~lane_sh);

  always_comb begin
    unique case (size_q[1:0])
      2'd0: begin
        lane_mask = 64'h0000_0000_0000_00FF;
        align_bad = 1'b0;
      end
      2'd1: begin
        lane_mask = 64'h0000_0000_0000_FFFF;
        align_bad = addr_q[0];
      end
      2'd2: begin
        lane_mask = 64'h0000_0000_FFFF_FFFF;
        align_bad = |addr_q[1:0];
      end
      default: begin
        lane_mask = 64'hFFFF_FFFF_FFFF_FFFF;
        align_bad = |addr_q[2:0];
      end
    endcase
  end

  always_comb begin
    ok_d     = 1'b0;
    err_d    = err_q;
    lock_d   = lock_q;
    we       = 1'b0;
    erase_go = 1'b0;
    unique case (kind_q)
      KindUnlock: begin
        if (lock_q) begin
          lock_d = 1'b0;
          ok_d   = 1'b1;
        end else begin
          err_d = ErrNone;
        end
      end
      KindLock: begin
        if (!lock_q) begin
          lock_d = 1'b1;
          ok_d   = 1'b1;
        end else begin
          err_d = ErrNone;
        end
      end
      KindProg: begin
        priority if (lock_q) begin
          err_d = ErrWrp;
        end else if (size_q[2]) begin
          err_d = ErrProg;
        end else if (align_bad) begin
          err_d = ErrPga;
        end else if (!in_range) begin
          err_d = ErrProg;
        end else if ((rd_q & want) != want) begin
          err_d = ErrProg;
        end else begin
          ok_d = 1'b1;
          we   = 1'b1;
        end
      end
      KindErase: begin
        if (lock_q) begin
          err_d = ErrWrp;
        end else begin
          ok_d     = 1'b1;
          erase_go = 1'b1;
        end
      end
      KindQuery: ok_d = 1'b1;
      default: ok_d = 1'b0;
    endcase
  end

  assign stat_o.erase_go   = erase_go;
  assign stat_o.sweep_last = (cnt_q == LastWord);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_en) begin
      mem[cnt_q] <= cmd_i.sweep_ones ? EraseWord : 64'd0;
    end else if (cmd_i.exec && we) begin
      mem[widx] <= new_word;
    end
    if (cmd_i.load) begin
      rd_q   <= mem[raddr];
      kind_q <= kind_i;
      size_q <= size_code_i;
      addr_q <= byte_address_i;
      data_q <= write_data_i;
    end
    if (cmd_i.exec) begin
      out_ok_q   <= ok_d;
      out_err_q  <= err_d;
      out_lock_q <= lock_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_q <= 1'b1;
      err_q  <= ErrNone;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.exec) begin
        lock_q <= lock_d;
        err_q  <= err_d;
      end
      if (cmd_i.sweep_en) begin
        cnt_q <= (cnt_q == LastWord) ? '0 : cnt_q + 1'b1;
      end
    end
  end

  assign ok_o         = out_ok_q;
  assign error_code_o = out_err_q;
  assign is_locked_o  = out_lock_q;

endmodule

### hw/rtl/nfpe_checker.sv
// Port-level checker for the NOR flash program/erase controller top level.
// Bound to nor_flash_program_erase_controller_unit; uses nfpe_pkg.
module nfpe_checker import nfpe_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid_i,
  input logic              s_axis_tready_o,
  input logic              m_axis_tvalid_o,
  input logic              m_axis_tready_i,
  input logic [MDataW-1:0] m_axis_tdata_o
);

  logic in_acc;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("result valid during reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result dropped or changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |=> !s_axis_tready_o)
    else $error("command taken while previous one executes");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(in_acc, 2))
    else $error("result without a command two cycles before");

endmodule

bind nor_flash_program_erase_controller_unit nfpe_checker u_nfpe_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
